>>> hdl/bpps_pkg.sv
// bpps_pkg: shared types and constants for the ball position servo
// no dependencies
`timescale 1ns / 1ps
package bpps_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_MODE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HOLD   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_P = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GAIN_I = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SCALE  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_ILIM   = 3'd6;

  localparam logic [2:0] LINK_NORMAL = 3'd1;
  localparam logic [2:0] LINK_SHORT  = 3'd2;
  localparam logic [2:0] LINK_DIR    = 3'd3;

  localparam logic [2:0] PH_WAIT = 3'd0;
  localparam logic [2:0] PH_ZERO = 3'd1;
  localparam logic [2:0] PH_POS  = 3'd2;
  localparam logic [2:0] PH_NEG  = 3'd3;
  localparam logic [2:0] PH_HOLD = 3'd4;

  localparam logic [1:0] TRK_MEAS = 2'd0;
  localparam logic [1:0] TRK_HELD = 2'd1;
  localparam logic [1:0] TRK_NONE = 2'd2;

  localparam int CenterUs  = 1500;
  localparam int TgtPos    = 50;
  localparam int TgtNeg    = -44;
  localparam int EdgeMm    = 45;
  localparam int RampStep  = 3;
  localparam int TolMm     = 10;
  localparam int SafeDelta = (20 * 2000) / 180;

  // last member sits in the lowest bits
  typedef struct packed {
    logic [1:0]  track_status;
    logic [2:0]  sequence_phase;
    logic [10:0] position_error_mm;
    logic [8:0]  pulse_offset_us;
    logic [11:0] servo_pulse_us;
  } result_t;
endpackage

>>> hdl/ball_position_pid_servo.sv
// ball_position_pid_servo: vision tracking, target sequencer and pid servo
// depends on bpps_pkg
`timescale 1ns / 1ps
//  channel | dir | handshake            | payload
//  s_axis  | in  | tvalid/tready        | tdata: ball_mm; tuser: link_state, side_negative
//  m_axis  | out | tvalid/tready        | tdata: pulse, offset, error, phase, status
//  cfg     | in  | cfg_valid_i/ready_o  | cfg_index_i, cfg_data_i
// a tick runs the input transfer, 30 multiply steps (three 10-step shift-add products),
// 26 restoring division steps, an output step and the result transfer, all on the
// single shared 34-bit add/subtract unit; the input is ready again once the result
// transfer has cleared the output valid
// reset sets all state to its defaults; an unread result or a pending register write holds off the input
module ball_position_pid_servo #(
  parameter int LOSS_HOLD_TICKS  = 60,
  parameter int START_HOLD_TICKS = 40,
  parameter int STABLE_TICKS     = 50,
  parameter int PHASE_MAX_TICKS  = 150,
  parameter int PULSE_MIN        = 500,
  parameter int PULSE_MAX        = 2500
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [8:0] ball_mm
  input  logic [3:0]  s_axis_tuser,  // [2:0] link_state, [3] side_negative
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] pulse, [20:12] offset, [31:21] error, [34:32] phase, [36:35] status
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i
);
  import bpps_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;
  localparam logic [2:0] S_SEND = 3'd4;

  // configuration
  logic        mode_q;
  logic [9:0]  hold_q, gp_q, gi_q, gd_q, scale_q;
  logic [14:0] ilim_q;

  // tracking and sequencer state
  logic [2:0]  phase_q, phase_d;
  logic signed [10:0] final_q, final_d, ramp_q, ramp_d, meas_q, meas_d, lgp_q, lgp_d;
  logic        lgv_q, lgv_d, mv_q, mv_d;
  logic [6:0]  loss_q, loss_d;
  logic [7:0]  pht_q, pht_d;
  logic [5:0]  stt_q, stt_d;
  logic signed [11:0] en_q, en_d, ep_q, ep_d;
  logic signed [16:0] es_q, es_d;
  logic [1:0]  trk_q, trk_d;

  // sequencer and shared adder datapath
  logic [2:0]  st_q;
  logic [4:0]  cnt_q;
  logic [1:0]  term_q;          // which product is being accumulated
  logic signed [33:0] acc_q;    // pid sum
  logic [16:0] mcand_q;         // magnitude of multiplicand
  logic        mneg_q;
  logic [9:0]  mplier_q;
  logic [33:0] rem_q, quo_q;
  logic        qneg_q;
  result_t     res_q;

  // register writes only between ticks, and they win over a new input
  assign s_axis_tready = (st_q == S_IDLE) && !m_axis_tvalid && !cfg_valid_i;
  assign cfg_ready_o   = (st_q == S_IDLE) && !m_axis_tvalid;
  assign m_axis_tdata  = {3'b0, res_q};

  wire in_fire = s_axis_tvalid && s_axis_tready;
  wire [2:0] link = s_axis_tuser[2:0];
  wire       neg  = s_axis_tuser[3];
  wire [8:0] ball_mm = s_axis_tdata[8:0];

  // front end: measurement, target sequencer and error, all combinational, registered when an input is accepted
  always_comb begin
    logic signed [10:0] mag, hold_ext;
    logic [11:0] emag;
    logic signed [17:0] sum;
    logic signed [16:0] lim;
    phase_d = phase_q; final_d = final_q; ramp_d = ramp_q; meas_d = meas_q;
    lgp_d = lgp_q; lgv_d = lgv_q; mv_d = mv_q; loss_d = loss_q;
    pht_d = pht_q; stt_d = stt_q; en_d = en_q; ep_d = ep_q; es_d = es_q;
    trk_d = trk_q;
    mag = '0; sum = '0; lim = '0;
    hold_ext = {hold_q[9], hold_q};
    if (link == LINK_NORMAL || link == LINK_SHORT || link == LINK_DIR) begin
      mag = (link == LINK_DIR) ? 11'(EdgeMm) : {2'b0, ball_mm};
      meas_d = neg ? -mag : mag;
      mv_d = 1'b1; lgv_d = 1'b1; lgp_d = meas_d; loss_d = '0; trk_d = TRK_MEAS;
    end else begin
      if (loss_q != 7'd127) loss_d = loss_q + 7'd1;
      if (lgv_q && int'(loss_d) <= LOSS_HOLD_TICKS) begin
        meas_d = lgp_q; mv_d = 1'b1; trk_d = TRK_HELD;
      end else begin
        mv_d = 1'b0; trk_d = TRK_NONE;
      end
    end
    emag = en_q[11] ? 12'(-en_q) : 12'(en_q);
    if (mode_q) begin
      if (phase_q == PH_WAIT) begin
        final_d = '0; ramp_d = '0; pht_d = '0; stt_d = '0;
        if (mv_d) begin
          phase_d = PH_ZERO; ramp_d = meas_d; es_d = '0; ep_d = '0;
        end
      end else if (!mv_d) begin
        final_d = '0; ramp_d = '0; phase_d = PH_ZERO; pht_d = '0; stt_d = '0;
      end else begin
        if (ramp_q < final_q) begin
          ramp_d = ramp_q + 11'sd3;
          if (ramp_d > final_q) ramp_d = final_q;
        end else if (ramp_q > final_q) begin
          ramp_d = ramp_q - 11'sd3;
          if (ramp_d < final_q) ramp_d = final_q;
        end
        if (pht_q != 8'd255) pht_d = pht_q + 8'd1;
        if (int'(emag) <= TolMm) begin
          if (stt_q != 6'd63) stt_d = stt_q + 6'd1;
        end else stt_d = '0;
        case (phase_q)
          PH_ZERO: begin
            final_d = '0;
            if (int'(pht_d) >= START_HOLD_TICKS) begin
              phase_d = PH_POS; final_d = 11'(TgtPos); ramp_d = meas_d;
              es_d = '0; ep_d = '0; pht_d = '0; stt_d = '0;
            end
          end
          PH_POS, PH_NEG: begin
            final_d = (phase_q == PH_POS) ? 11'(TgtPos) : 11'(TgtNeg);
            if (int'(stt_d) >= STABLE_TICKS || int'(pht_d) >= PHASE_MAX_TICKS) begin
              phase_d = phase_q + 3'd1; final_d = 11'(TgtNeg); ramp_d = meas_d;
              es_d = '0; ep_d = '0; pht_d = '0; stt_d = '0;
            end
          end
          PH_HOLD: final_d = 11'(TgtNeg);
          default: begin final_d = '0; ramp_d = '0; end
        endcase
      end
    end else begin
      phase_d = PH_HOLD; final_d = hold_ext; ramp_d = hold_ext;
    end
    if (!mv_d) begin
      en_d = '0; ep_d = '0; es_d = '0;
    end else begin
      en_d = 12'(ramp_d) - 12'(meas_d);
      sum = 18'(es_d) + 18'(en_d);
      lim = {2'b0, ilim_q};
      if (sum > 18'(lim)) es_d = lim;
      else if (sum < -18'(lim)) es_d = -lim;
      else es_d = 17'(sum);
    end
  end

  // one shared 34-bit adder: shift-add products, then restoring division
  // divisor steps that do not fit in 34 bits exceed any dividend and never subtract
  wire [9:0]  dvs = (scale_q == 10'd0) ? 10'd1 : scale_q;
  wire [34:0] dsh = {25'b0, dvs} << cnt_q;
  wire [33:0] addend = (st_q == S_MUL)
      ? (mneg_q ? ~({17'b0, mcand_q} << cnt_q) : ({17'b0, mcand_q} << cnt_q))
      : ~dsh[33:0];
  wire [33:0] base = (st_q == S_MUL) ? acc_q : rem_q;
  wire        cin  = (st_q == S_MUL) ? mneg_q : 1'b1;
  wire [34:0] alu  = {1'b0, base} + {1'b0, addend} + 35'(cin);
  wire        div_fit = alu[34] && !dsh[34];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic signed [11:0] dterm;
    logic [16:0] opnd;
    logic signed [34:0] q;
    logic signed [12:0] dl;
    logic signed [13:0] pl;
    if (!rst_ni) begin
      mode_q <= 1'b1; hold_q <= '0; gp_q <= 10'd80; gi_q <= '0; gd_q <= 10'd200;
      scale_q <= 10'd100; ilim_q <= 15'd3000;
      phase_q <= PH_WAIT; final_q <= '0; ramp_q <= '0; meas_q <= '0; lgp_q <= '0;
      lgv_q <= 1'b0; mv_q <= 1'b0; loss_q <= '0; pht_q <= '0; stt_q <= '0;
      en_q <= '0; ep_q <= '0; es_q <= '0; trk_q <= TRK_MEAS;
      st_q <= S_IDLE; cnt_q <= '0; term_q <= '0; m_axis_tvalid <= 1'b0;
      acc_q <= '0; mcand_q <= '0; mneg_q <= 1'b0; mplier_q <= '0;
      rem_q <= '0; quo_q <= '0; qneg_q <= 1'b0; res_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_MODE: begin
            mode_q <= cfg_data_i[0]; phase_q <= cfg_data_i[0] ? PH_WAIT : PH_HOLD;
            pht_q <= '0; stt_q <= '0;
          end
          REG_HOLD:   hold_q  <= cfg_data_i[9:0];
          REG_GAIN_P: gp_q    <= cfg_data_i[9:0];
          REG_GAIN_I: gi_q    <= cfg_data_i[9:0];
          REG_GAIN_D: gd_q    <= cfg_data_i[9:0];
          REG_SCALE:  scale_q <= cfg_data_i[9:0];
          REG_ILIM:   ilim_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (st_q)
        S_IDLE: if (in_fire) begin
          phase_q <= phase_d; final_q <= final_d; ramp_q <= ramp_d; meas_q <= meas_d;
          lgp_q <= lgp_d; lgv_q <= lgv_d; mv_q <= mv_d; loss_q <= loss_d;
          pht_q <= pht_d; stt_q <= stt_d; en_q <= en_d; es_q <= es_d; trk_q <= trk_d;
          ep_q <= ep_d;
          acc_q <= '0; cnt_q <= '0; term_q <= 2'd0;
          mneg_q <= en_d[11];
          mcand_q <= en_d[11] ? 17'(-en_d) : 17'(en_d);
          mplier_q <= gp_q;
          st_q <= S_MUL;
        end
        S_MUL: begin
          if (mplier_q[0]) acc_q <= alu[33:0];
          if (cnt_q != 5'd9) begin
            mplier_q <= mplier_q >> 1;
            cnt_q <= cnt_q + 5'd1;
          end else begin
            term_q <= term_q + 2'd1;
            case (term_q)
              2'd0: begin
                cnt_q <= '0;
                mneg_q <= es_q[16]; opnd = es_q[16] ? 17'(-es_q) : 17'(es_q);
                mcand_q <= opnd; mplier_q <= gi_q;
              end
              2'd1: begin
                cnt_q <= '0;
                dterm = en_q - ep_q;
                mneg_q <= dterm[11]; opnd = dterm[11] ? 17'(-dterm) : 17'(dterm);
                mcand_q <= opnd; mplier_q <= gd_q;
              end
              default: begin
                // divide magnitude; acc holds final sum after this step
                st_q <= S_DIV; cnt_q <= 5'd25;
                qneg_q <= (mplier_q[0] ? alu[33] : acc_q[33]);
                rem_q <= (mplier_q[0] ? alu[33] : acc_q[33])
                         ? -(mplier_q[0] ? alu[33:0] : acc_q) : (mplier_q[0] ? alu[33:0] : acc_q);
                quo_q <= '0;
              end
            endcase
          end
        end
        S_DIV: begin
          quo_q <= {quo_q[32:0], div_fit};
          if (div_fit) rem_q <= alu[33:0];
          if (cnt_q == 5'd0) st_q <= S_OUT;
          else cnt_q <= cnt_q - 5'd1;
        end
        S_OUT: begin
          q = qneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
          if (q > 35'sd222) dl = 13'sd222;
          else if (q < -35'sd222) dl = -13'sd222;
          else dl = 13'(q);
          if (!mv_q) dl = '0;
          pl = 14'(CenterUs) + 14'(dl);
          if (pl < 14'(PULSE_MIN)) pl = 14'(PULSE_MIN);
          if (pl > 14'(PULSE_MAX)) pl = 14'(PULSE_MAX);
          res_q.servo_pulse_us <= 12'(pl);
          res_q.pulse_offset_us <= 9'(dl);
          res_q.position_error_mm <= 11'(en_q);
          res_q.sequence_phase <= phase_q;
          res_q.track_status <= trk_q;
          if (mv_q) ep_q <= en_q;
          m_axis_tvalid <= 1'b1;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/bpps_checker.sv
// bpps_checker: port-level checks for the ball position servo
// depends on bpps_pkg; bound to ball_position_pid_servo
`timescale 1ns / 1ps
module bpps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  import bpps_pkg::*;
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after transfer");
  a_noready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result waits");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[36:35] == TRK_NONE |-> m_axis_tdata[11:0] == 12'd1500)
    else $error("pulse not centred");
endmodule

bind ball_position_pid_servo bpps_checker u_chk (.*);
